FILE: design/glst_pkg.sv
// Shared command codes, constants and controller/datapath interface types for the list store.
package glst_pkg;

   // Command codes on req_command
   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_GET    = 3'd2;
   localparam logic [2:0] CMD_COUNT  = 3'd3;
   localparam logic [2:0] CMD_CAP    = 3'd4;

   // Capacity taken by the first add, and the answer for a get that misses
   localparam int unsigned FIRST_CAPACITY = 10;
   localparam logic signed [31:0] ANSWER_MISS = -32'sd1;

   // Controller to datapath
   typedef struct packed {
      logic append;        // write operand at the tail, grow capacity if due
      logic answer_count;  // load count into the result register
      logic answer_cap;    // load capacity into the result register
      logic answer_miss;   // load the miss answer into the result register
      logic get_issue;     // read the entry addressed by the operand
      logic get_load;      // load the read entry into the result register
      logic scan_start;    // latch the key and rewind the scan
      logic scan_run;      // advance the search-and-shift pipeline
      logic scan_finish;   // drop the count if the key was found
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;   // result register is empty or drains this cycle
      logic add_fit;    // the store has room for one more entry
      logic get_hit;    // the get index on the request is inside the list
      logic scan_done;  // every entry has been read and handled
   } dp_status_type;

endpackage

FILE: design/glst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module glst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/glst_ctrl.sv
// Command sequencer: decodes request beats and steps the datapath through get and remove.
module glst_ctrl import glst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_command,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GET_WAIT,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A beat is taken only from idle, with room for any answer it makes
   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_ADD: begin
                     cmd.append = status.add_fit;
                  end
                  CMD_REMOVE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  CMD_GET: begin
                     if (status.get_hit) begin
                        cmd.get_issue = 1'b1;
                        state_in      = ST_GET_WAIT;
                     end else begin
                        cmd.answer_miss = 1'b1;
                     end
                  end
                  CMD_COUNT: begin
                     cmd.answer_count = 1'b1;
                  end
                  CMD_CAP: begin
                     cmd.answer_cap = 1'b1;
                  end
                  default: begin
                     // unused codes are dropped
                  end
               endcase
            end
         end
         ST_GET_WAIT: begin
            cmd.get_load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               cmd.scan_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/glst_datapath.sv
// Counters, entry RAM, search-and-shift pipeline and result register of the list store.
module glst_datapath import glst_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_answer,
   input  dp_cmd_type         cmd,
   output dp_status_type      status
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int CW   = $clog2(2 * DEPTH);

   // Counters
   logic [CNTW-1:0] count_ff, count_in;
   logic [CW-1:0]   cap_ff, cap_in;
   logic [CW-1:0]   cap_base;

   // Search-and-shift pipeline
   logic [31:0]     key_ff, key_in;
   logic [CNTW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0]   pipe_addr_ff, pipe_addr_in;
   logic            pipe_valid_ff, pipe_valid_in;
   logic            found_ff, found_in;
   logic            scan_issue;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] answer_ff, answer_in;

   // RAM ports
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [31:0]     wr_data;
   logic [AW-1:0]   rd_addr;
   logic [31:0]     rd_data;

   glst_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status toward the controller
   assign scan_issue       = scan_addr_ff < count_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.add_fit   = count_ff < CNTW'(DEPTH);
   assign status.get_hit   = !req_operand[31] && ($unsigned(req_operand) < 32'(count_ff));
   assign status.scan_done = !scan_issue && !pipe_valid_ff;

   // First add sets the capacity before the grow check
   assign cap_base = (cap_ff == '0) ? CW'(FIRST_CAPACITY) : cap_ff;

   // RAM address and write selection
   always_comb begin
      rd_addr = cmd.get_issue ? req_operand[AW-1:0] : scan_addr_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = req_operand;
      if (cmd.append) begin
         wr_en = 1'b1;
      end else if (cmd.scan_run && pipe_valid_ff && found_ff) begin
         // move the entry one place toward the head
         wr_en   = 1'b1;
         wr_addr = pipe_addr_ff - AW'(1);
         wr_data = rd_data;
      end
   end

   // Counter and scan next-state
   always_comb begin
      count_in      = count_ff;
      cap_in        = cap_ff;
      key_in        = key_ff;
      scan_addr_in  = scan_addr_ff;
      pipe_addr_in  = pipe_addr_ff;
      pipe_valid_in = pipe_valid_ff;
      found_in      = found_ff;

      if (cmd.append) begin
         count_in = count_ff + CNTW'(1);
         if (CW'(count_ff) == cap_base) begin
            cap_in = cap_base + (cap_base >> 1);
         end else begin
            cap_in = cap_base;
         end
      end

      if (cmd.scan_start) begin
         key_in        = req_operand;
         scan_addr_in  = '0;
         pipe_valid_in = 1'b0;
         found_in      = 1'b0;
      end

      if (cmd.scan_run) begin
         pipe_valid_in = scan_issue;
         pipe_addr_in  = scan_addr_ff[AW-1:0];
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + CNTW'(1);
         end
         if (pipe_valid_ff && !found_ff && (rd_data == key_ff)) begin
            found_in = 1'b1;
         end
      end

      if (cmd.scan_finish && found_ff) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   // Result register next-state
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      answer_in    = answer_ff;
      if (cmd.answer_count) begin
         rsp_valid_in = 1'b1;
         answer_in    = $signed(32'(count_ff));
      end else if (cmd.answer_cap) begin
         rsp_valid_in = 1'b1;
         answer_in    = $signed(32'(cap_ff));
      end else if (cmd.answer_miss) begin
         rsp_valid_in = 1'b1;
         answer_in    = ANSWER_MISS;
      end else if (cmd.get_load) begin
         rsp_valid_in = 1'b1;
         answer_in    = $signed(rd_data);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cap_ff        <= '0;
         pipe_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         pipe_valid_ff <= pipe_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      scan_addr_ff <= scan_addr_in;
      pipe_addr_ff <= pipe_addr_in;
      answer_ff    <= answer_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = answer_ff;

endmodule

FILE: design/growable_list_store.sv
// List store top level: command sequencer and datapath, with interface checks.
//
// Usage:
//   Request beats (req_command, req_operand) enter on a valid/ready channel.
//   Add appends req_operand, remove deletes the first entry equal to it, get
//   reads the entry at index req_operand, and the count and capacity
//   queries return those counters. Add and remove return nothing; the
//   three reads return one beat on rsp_answer over the rsp_ channel.
//   Sequencing, one request at a time:
//     add, count, capacity, missing get: any answer shows next cycle.
//     get inside the list: waits on the registered RAM read.
//     remove: runs the search-and-shift pipeline, which reads one entry
//       and writes one shifted entry per cycle on the RAM, then drains
//       one stage.
//   The longest request is a remove on a full store.
//   req_ready drops while a get or remove is under way, and also while an
//   answer waits and rsp_ready is low, so a stalled receiver holds off new
//   requests. Reset clears count and capacity; entry contents are not
//   cleared and no clearing pass is run.
module growable_list_store import glst_pkg::*; #(
   parameter int DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_answer
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   glst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   glst_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_answer  (rsp_answer),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   // A request is only taken when any answer it makes has a free slot
   a_ready_needs_slot: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("request taken while answer slot is occupied");

   // Counter queries answer in the next cycle
   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_command == CMD_COUNT || req_command == CMD_CAP)) |=> rsp_valid)
      else $error("counter query gave no answer beat");

   // A get inside the list blocks requests during the RAM read, then answers
   a_get_hit_answers: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_GET && dp_status.get_hit)
      |=> (!req_ready && !rsp_valid) ##1 rsp_valid)
      else $error("get inside the list did not answer after the RAM read");

   // A remove holds off the next request while it scans
   a_remove_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_REMOVE) |=> !req_ready)
      else $error("request taken during a remove scan");

endmodule
